/* design/lpsi_pkg.sv */
// shared types and constants of the length-prefixed string indexer
`default_nettype none
package lpsi_pkg;

	localparam int unsigned OFFSET_W = 16;
	localparam int unsigned POS_W = 17;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// parse phases
	localparam logic [1:0] PH_LEN_LO = 2'd0;
	localparam logic [1:0] PH_LEN_HI = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	// result status codes
	localparam logic [1:0] ST_ENTRY = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	// register indexes
	localparam logic [1:0] REG_START_OFFSET = 2'd0;
	localparam logic [1:0] REG_END_OFFSET = 2'd1;
	localparam logic [1:0] REG_STRING_COUNT = 2'd2;

	typedef struct packed {
		logic [OFFSET_W-1:0] start_offset;
		logic [OFFSET_W-1:0] end_offset;
		logic [OFFSET_W-1:0] string_count;
	} cfg_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] string_index;
		logic [OFFSET_W-1:0] payload_offset;
		logic [1:0] status;
		logic last;
	} result_t;

	// up to two results pushed into the output queue per word
	typedef struct packed {
		logic [1:0] count;
		result_t r0;
		result_t r1;
	} push_t;

endpackage
`default_nettype wire

/* design/lpsi_in_if.sv */
// byte channel into the indexer
`default_nettype none
interface lpsi_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic begin_req;

	modport source (output valid, output data_byte, output begin_req, input ready);
	modport sink (input valid, input data_byte, input begin_req, output ready);
endinterface
`default_nettype wire

/* design/lpsi_out_if.sv */
// result channel out of the indexer
`default_nettype none
interface lpsi_out_if;
	logic valid;
	logic ready;
	logic [15:0] string_index;
	logic [15:0] payload_offset;
	logic [1:0] status;
	logic last;

	modport source (output valid, output string_index, output payload_offset,
		output status, output last, input ready);
	modport sink (input valid, input string_index, input payload_offset,
		input status, input last, output ready);
endinterface
`default_nettype wire

/* design/lpsi_cfg_if.sv */
// register write channel of the indexer
`default_nettype none
interface lpsi_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* design/length_prefixed_string_indexer_unit.sv */
// length-prefixed string indexer: one section byte per word, offset entries out
// a result word passes the input register and the result queue before it is offered
// throughput: one byte per cycle, but input stalls while the four-entry result queue has
// fewer than two free slots; a byte giving two results fills two queue slots
// reset: registers to zero, parse at length low byte, position zero, queue empty
`default_nettype none
module length_prefixed_string_indexer_unit
	import lpsi_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	lpsi_in_if.sink bytes,
	lpsi_out_if.source results,
	lpsi_cfg_if.sink cfg
);

	cfg_t cfg_q;
	push_t push;
	logic space_ok;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_START_OFFSET: cfg_q.start_offset <= cfg.data;
				REG_END_OFFSET: cfg_q.end_offset <= cfg.data;
				REG_STRING_COUNT: cfg_q.string_count <= cfg.data;
				default: begin
					// unmapped index, write ignored
				end
			endcase
		end
	end

	lpsi_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(bytes),
		.cfg(cfg_q),
		.space_ok(space_ok),
		.push(push)
	);

	lpsi_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.space_ok(space_ok),
		.results(results)
	);

endmodule
`default_nettype wire

/* design/lpsi_parse.sv */
// input register and single-pass parse logic with the section state
`default_nettype none
module lpsi_parse
	import lpsi_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	lpsi_in_if.sink bytes,
	input wire cfg_t cfg,
	input wire logic space_ok,
	output push_t push
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic begin_s1;
	logic advance;

	logic [1:0] phase_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0] len_lo_q;
	logic [OFFSET_W-1:0] left_q;
	logic [OFFSET_W-1:0] done_q;
	logic fin_q;

	logic [1:0] phase_d;
	logic [POS_W-1:0] pos_d;
	logic [7:0] len_lo_d;
	logic [OFFSET_W-1:0] left_d;
	logic [OFFSET_W-1:0] done_d;
	logic fin_d;
	push_t push_d;

	assign advance = valid_s1 && space_ok;
	assign bytes.ready = !valid_s1 || space_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.data_byte;
			begin_s1 <= bytes.begin_req;
		end
	end

	always_comb begin
		logic [POS_W:0] pay;
		logic [POS_W:0] pay_end;
		logic [OFFSET_W-1:0] len;
		logic entry_v;
		logic final_v;
		logic final_ok;
		logic complete;
		result_t entry_r;
		result_t final_r;

		phase_d = phase_q;
		pos_d = pos_q;
		len_lo_d = len_lo_q;
		left_d = left_q;
		done_d = done_q;
		fin_d = fin_q;
		entry_v = 1'b0;
		final_v = 1'b0;
		final_ok = 1'b0;
		complete = 1'b0;
		pay = '0;
		pay_end = '0;
		len = '0;

		if (begin_s1) begin
			phase_d = PH_LEN_LO;
			pos_d = {1'b0, cfg.start_offset};
			len_lo_d = '0;
			left_d = '0;
			done_d = '0;
			fin_d = 1'b0;
		end

		if (begin_s1 && cfg.string_count == '0) begin
			final_v = 1'b1;
			final_ok = (cfg.start_offset == cfg.end_offset);
		end else if (fin_d) begin
			// section closed, byte dropped
		end else if (done_d >= cfg.string_count) begin
			final_v = 1'b1;
		end else begin
			case (phase_d)
				PH_LEN_LO: begin
					if ({1'b0, pos_d} + (POS_W+1)'(2) > {2'b00, cfg.end_offset}) begin
						final_v = 1'b1;
					end else begin
						len_lo_d = byte_s1;
						pos_d = pos_d + POS_W'(1);
						phase_d = PH_LEN_HI;
					end
				end
				PH_LEN_HI: begin
					len = {byte_s1, len_lo_d};
					pay = {1'b0, pos_d} + (POS_W+1)'(1);
					pay_end = pay + {2'b00, len};
					if (pay > (POS_W+1)'(16'hFFFF) || pay_end > {2'b00, cfg.end_offset}) begin
						final_v = 1'b1;
					end else begin
						entry_v = 1'b1;
						pos_d = pay[POS_W-1:0];
						if (len == '0) begin
							complete = 1'b1;
						end else begin
							left_d = len;
							phase_d = PH_PAYLOAD;
						end
					end
				end
				default: begin
					pos_d = pos_d + POS_W'(1);
					left_d = left_d - OFFSET_W'(1);
					if (left_d == '0) begin
						complete = 1'b1;
					end
				end
			endcase
		end

		entry_r.string_index = done_d;
		entry_r.payload_offset = pay[OFFSET_W-1:0];
		entry_r.status = ST_ENTRY;
		entry_r.last = 1'b0;

		if (complete) begin
			done_d = done_d + OFFSET_W'(1);
			phase_d = PH_LEN_LO;
			if (done_d >= cfg.string_count) begin
				final_v = 1'b1;
				final_ok = (pos_d == {1'b0, cfg.end_offset});
			end
		end

		if (final_v) begin
			fin_d = 1'b1;
		end

		final_r.string_index = '0;
		final_r.payload_offset = '0;
		final_r.status = final_ok ? ST_DONE : ST_ERROR;
		final_r.last = 1'b1;

		push_d.r1 = final_r;
		if (entry_v) begin
			push_d.r0 = entry_r;
			push_d.count = final_v ? 2'd2 : 2'd1;
		end else begin
			push_d.r0 = final_r;
			push_d.count = final_v ? 2'd1 : 2'd0;
		end
	end

	always_comb begin
		push = push_d;
		if (!advance) begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN_LO;
			pos_q <= '0;
			len_lo_q <= '0;
			left_q <= '0;
			done_q <= '0;
			fin_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			len_lo_q <= len_lo_d;
			left_q <= left_d;
			done_q <= done_d;
			fin_q <= fin_d;
		end
	end

endmodule
`default_nettype wire

/* design/lpsi_out_fifo.sv */
// small result queue: takes up to two results a cycle, gives one when the reader is ready
`default_nettype none
module lpsi_out_fifo
	import lpsi_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire push_t push,
	output logic space_ok,
	lpsi_out_if.source results
);

	result_t mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic pop;
	result_t head;

	assign space_ok = cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
	assign head = mem_q[rd_ptr_q];
	assign pop = results.valid && results.ready;

	assign results.valid = cnt_q != '0;
	assign results.string_index = head.string_index;
	assign results.payload_offset = head.payload_offset;
	assign results.status = head.status;
	assign results.last = head.last;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
		end
	end

endmodule
`default_nettype wire
